@@ rtl/udpf_pkg.sv @@
package udpf_pkg;

  // default store size and frame layout
  localparam int MaxPayloadDef = 1024;
  localparam int HdrLen        = 42;
  localparam int PaddrW        = 6;
  localparam int PdataW        = 64;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // result status codes
  localparam logic [1:0] ST_PUSHED  = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_BYTE    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // register indexes (byte address 8*index)
  localparam logic [2:0] REG_DEST_MAC = 3'd0;
  localparam logic [2:0] REG_SRC_MAC  = 3'd1;
  localparam logic [2:0] REG_SRC_IP   = 3'd2;
  localparam logic [2:0] REG_DEST_IP  = 3'd3;
  localparam logic [2:0] REG_SRC_PORT = 3'd4;
  localparam logic [2:0] REG_DEST_PORT = 3'd5;

  // header constants
  localparam logic [7:0]  ETH_TYPE_HI  = 8'h08;
  localparam logic [7:0]  IP_VER_IHL   = 8'h45;
  localparam logic [7:0]  IP_ID_LO     = 8'h01;
  localparam logic [7:0]  IP_FLAGS_HI  = 8'h40;
  localparam logic [7:0]  IP_TTL       = 8'h62;
  localparam logic [7:0]  IP_PROTO_UDP = 8'h11;
  localparam logic [15:0] IP_UDP_HLEN  = 16'd28;
  localparam logic [15:0] UDP_HLEN     = 16'd8;

  // sum of the fixed header words: 4500 + 0001 + 4000 + 6211
  localparam logic [15:0] CSUM_BASE  = 16'hE712;
  localparam logic [2:0]  CSUM_LAST  = 3'd4;

  typedef struct packed {
    logic       operation;
    logic [7:0] payload_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [15:0] tot_len;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } csum_req_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] value;
  } csum_rsp_t;

endpackage

@@ rtl/udpf_ram.sv @@
module udpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/udpf_csum.sv @@
module udpf_csum (
  input  logic                clk,
  input  logic                rst_n,
  input  udpf_pkg::csum_req_t req,
  output udpf_pkg::csum_rsp_t rsp
);

  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] word;
  logic [16:0] raw_sum;

  // header word for the current step
  always_comb begin
    case (step_r)
      3'd0:    word = req.tot_len;
      3'd1:    word = req.src_ip[31:16];
      3'd2:    word = req.src_ip[15:0];
      3'd3:    word = req.dst_ip[31:16];
      3'd4:    word = req.dst_ip[15:0];
      default: word = 16'h0000;
    endcase
  end

  // shared ones' complement adder with end-around carry
  assign raw_sum = {1'b0, acc_r} + {1'b0, word};

  always_comb begin
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (req.start) begin
      acc_nxt  = udpf_pkg::CSUM_BASE;
      step_nxt = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = raw_sum[15:0] + {15'd0, raw_sum[16]};
      if (step_r == udpf_pkg::CSUM_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 16'h0000;
      step_r <= 3'd0;
      busy_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.value = ~acc_r;

endmodule

@@ rtl/udp_ipv4_tx_framer.sv @@
// channel  direction  beat                    handshake
// in_      input      in_item_t  push / pull  in_valid, in_stall
// out_     output     out_item_t one result   out_valid, out_stall
// apb      input      64-bit register write   psel, penable, pwrite, pready
//
// every item gives one result beat; the block takes no new item until that beat is taken
// push: a push that closes the segment first waits in S_SUM for the checksum accumulation
// pull of a header byte: direct; of a payload byte: via S_RD (registered store read)
// a stall on out_ holds the result and the block; synchronous active-low reset, no
// clearing pass (the segment store is only read where it has been written)
module udp_ipv4_tx_framer #(
  parameter int MAX_PAYLOAD = udpf_pkg::MaxPayloadDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  udpf_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output udpf_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [udpf_pkg::PaddrW-1:0]       paddr,
  input  logic [udpf_pkg::PdataW-1:0]       pwdata,
  output logic [udpf_pkg::PdataW-1:0]       prdata,
  output logic                              pready
);

  localparam int AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int FCW = $clog2(MAX_PAYLOAD + 1);
  localparam int RPW = $clog2(udpf_pkg::HdrLen + MAX_PAYLOAD);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [47:0] dmac_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r;
  logic [31:0] dip_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;

  logic [FCW-1:0] fill_r, fill_nxt;
  logic           pend_r, pend_nxt;
  logic [RPW-1:0] rp_r, rp_nxt;

  logic [1:0] ostat_r, ostat_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       olast_r, olast_nxt;

  logic           accept_in;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;
  logic [FCW-1:0] fill_inc;
  logic [RPW-1:0] rp_off;
  logic [15:0]    tot_len;
  logic [15:0]    udp_len;
  logic [7:0]     hdr_byte;
  logic           is_last;
  logic           ram_we;
  logic           ram_re;
  logic [7:0]     ram_rdata;
  logic           csum_start;

  udpf_pkg::csum_req_t csum_req;
  udpf_pkg::csum_rsp_t csum_rsp;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmac_r  <= 48'd0;
      smac_r  <= 48'd0;
      sip_r   <= 32'd0;
      dip_r   <= 32'd0;
      sport_r <= 16'd0;
      dport_r <= 16'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        udpf_pkg::REG_DEST_MAC:  dmac_r  <= pwdata[47:0];
        udpf_pkg::REG_SRC_MAC:   smac_r  <= pwdata[47:0];
        udpf_pkg::REG_SRC_IP:    sip_r   <= pwdata[31:0];
        udpf_pkg::REG_DEST_IP:   dip_r   <= pwdata[31:0];
        udpf_pkg::REG_SRC_PORT:  sport_r <= pwdata[15:0];
        udpf_pkg::REG_DEST_PORT: dport_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      udpf_pkg::REG_DEST_MAC:  prdata = {16'd0, dmac_r};
      udpf_pkg::REG_SRC_MAC:   prdata = {16'd0, smac_r};
      udpf_pkg::REG_SRC_IP:    prdata = {32'd0, sip_r};
      udpf_pkg::REG_DEST_IP:   prdata = {32'd0, dip_r};
      udpf_pkg::REG_SRC_PORT:  prdata = {48'd0, sport_r};
      udpf_pkg::REG_DEST_PORT: prdata = {48'd0, dport_r};
      default:                 prdata = 64'd0;
    endcase
  end

  // lengths from the segment fill
  assign tot_len = udpf_pkg::IP_UDP_HLEN + 16'(fill_r);
  assign udp_len = udpf_pkg::UDP_HLEN + 16'(fill_r);

  // checksum unit
  assign csum_req.start   = csum_start;
  assign csum_req.tot_len = tot_len;
  assign csum_req.src_ip  = sip_r;
  assign csum_req.dst_ip  = dip_r;

  udpf_csum u_csum (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (csum_req),
    .rsp   (csum_rsp)
  );

  // segment store
  assign rp_off = rp_r - RPW'(udpf_pkg::HdrLen);

  udpf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_data.payload_byte),
    .re    (ram_re),
    .raddr (rp_off[AW-1:0]),
    .rdata (ram_rdata)
  );

  // header byte at the read position
  always_comb begin
    case (rp_r[5:0])
      6'd0:    hdr_byte = dmac_r[47:40];
      6'd1:    hdr_byte = dmac_r[39:32];
      6'd2:    hdr_byte = dmac_r[31:24];
      6'd3:    hdr_byte = dmac_r[23:16];
      6'd4:    hdr_byte = dmac_r[15:8];
      6'd5:    hdr_byte = dmac_r[7:0];
      6'd6:    hdr_byte = smac_r[47:40];
      6'd7:    hdr_byte = smac_r[39:32];
      6'd8:    hdr_byte = smac_r[31:24];
      6'd9:    hdr_byte = smac_r[23:16];
      6'd10:   hdr_byte = smac_r[15:8];
      6'd11:   hdr_byte = smac_r[7:0];
      6'd12:   hdr_byte = udpf_pkg::ETH_TYPE_HI;
      6'd14:   hdr_byte = udpf_pkg::IP_VER_IHL;
      6'd16:   hdr_byte = tot_len[15:8];
      6'd17:   hdr_byte = tot_len[7:0];
      6'd19:   hdr_byte = udpf_pkg::IP_ID_LO;
      6'd20:   hdr_byte = udpf_pkg::IP_FLAGS_HI;
      6'd22:   hdr_byte = udpf_pkg::IP_TTL;
      6'd23:   hdr_byte = udpf_pkg::IP_PROTO_UDP;
      6'd24:   hdr_byte = csum_rsp.value[15:8];
      6'd25:   hdr_byte = csum_rsp.value[7:0];
      6'd26:   hdr_byte = sip_r[31:24];
      6'd27:   hdr_byte = sip_r[23:16];
      6'd28:   hdr_byte = sip_r[15:8];
      6'd29:   hdr_byte = sip_r[7:0];
      6'd30:   hdr_byte = dip_r[31:24];
      6'd31:   hdr_byte = dip_r[23:16];
      6'd32:   hdr_byte = dip_r[15:8];
      6'd33:   hdr_byte = dip_r[7:0];
      6'd34:   hdr_byte = sport_r[15:8];
      6'd35:   hdr_byte = sport_r[7:0];
      6'd36:   hdr_byte = dport_r[15:8];
      6'd37:   hdr_byte = dport_r[7:0];
      6'd38:   hdr_byte = udp_len[15:8];
      6'd39:   hdr_byte = udp_len[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  assign accept_in = in_valid && !in_stall;
  assign fill_inc  = fill_r + FCW'(1);
  assign is_last   = ({1'b0, rp_r} + (RPW+1)'(1)) >=
                     ((RPW+1)'(udpf_pkg::HdrLen) + (RPW+1)'(fill_r));

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    pend_nxt   = pend_r;
    rp_nxt     = rp_r;
    ostat_nxt  = ostat_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    csum_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          obyte_nxt = 8'h00;
          olast_nxt = 1'b0;
          state_nxt = S_OUT;
          if (in_data.operation == udpf_pkg::OP_PUSH) begin
            if (pend_r) begin
              ostat_nxt = udpf_pkg::ST_REFUSED;
            end else begin
              ostat_nxt = udpf_pkg::ST_PUSHED;
              ram_we    = 1'b1;
              fill_nxt  = fill_inc;
              // segment closes: freeze the header checksum
              if (in_data.end_of_message || (fill_inc >= FCW'(MAX_PAYLOAD))) begin
                pend_nxt   = 1'b1;
                rp_nxt     = '0;
                csum_start = 1'b1;
                state_nxt  = S_SUM;
              end
            end
          end else if (pend_r) begin
            ostat_nxt = udpf_pkg::ST_BYTE;
            olast_nxt = is_last;
            if (is_last) begin
              pend_nxt = 1'b0;
              fill_nxt = '0;
              rp_nxt   = '0;
            end else begin
              rp_nxt = rp_r + RPW'(1);
            end
            if (rp_r >= RPW'(udpf_pkg::HdrLen)) begin
              ram_re    = 1'b1;
              state_nxt = S_RD;
            end else begin
              obyte_nxt = hdr_byte;
            end
          end else begin
            ostat_nxt = udpf_pkg::ST_EMPTY;
          end
        end
      end
      S_SUM: begin
        if (!csum_rsp.busy) begin
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        obyte_nxt = ram_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
      rp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      rp_r    <= rp_nxt;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_data.status     = ostat_r;
  assign out_data.frame_byte = obyte_r;
  assign out_data.frame_last = olast_r;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int SegBytes      = udpf_pkg::MaxPayloadDef;
  localparam int FrameHdrBytes = 42;
  localparam int IdleLimit     = 4000;
  localparam int LongHold      = 400;
  localparam logic [2:0] RegUnused = 3'd6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  udpf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  udpf_pkg::out_item_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [udpf_pkg::PaddrW-1:0] paddr = '0;
  logic [udpf_pkg::PdataW-1:0] pwdata = '0;
  logic [udpf_pkg::PdataW-1:0] prdata;
  logic pready;

  udp_ipv4_tx_framer #(.MAX_PAYLOAD(SegBytes)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // framer state as the testbench sees it
  logic [47:0] cfg_dest_mac = '0;
  logic [47:0] cfg_src_mac = '0;
  logic [31:0] cfg_src_ip = '0;
  logic [31:0] cfg_dest_ip = '0;
  logic [15:0] cfg_src_port = '0;
  logic [15:0] cfg_dest_port = '0;
  logic [7:0] seg_bytes [SegBytes];
  int seg_fill;
  bit frame_ready;
  int pull_pos;
  logic [15:0] frame_csum;

  udpf_pkg::in_item_t pending_beats[$];
  udpf_pkg::out_item_t results_due[$];

  int mismatches = 0;
  int results_taken = 0;
  int pushes_seen = 0, refused_seen = 0, bytes_seen = 0, empty_seen = 0, frames_seen = 0;
  int cfg_writes = 0;

  // ones' complement ipv4 header checksum with end-around carry
  function automatic logic [15:0] ip_checksum(int n);
    logic [15:0] tot;
    logic [31:0] acc;
    tot = 16'(28 + n);
    acc = 32'h4500 + 32'(tot) + 32'h0001 + 32'h4000 + 32'h6211
        + 32'(cfg_src_ip[31:16]) + 32'(cfg_src_ip[15:0])
        + 32'(cfg_dest_ip[31:16]) + 32'(cfg_dest_ip[15:0]);
    acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    return ~acc[15:0];
  endfunction

  // byte at a given position of the pending frame, header fields live
  function automatic logic [7:0] frame_byte_at(int pos);
    logic [15:0] tot_len;
    logic [15:0] udp_len;
    tot_len = 16'(28 + seg_fill);
    udp_len = 16'(8 + seg_fill);
    if (pos < 6) return cfg_dest_mac[8*(5-pos) +: 8];
    if (pos < 12) return cfg_src_mac[8*(11-pos) +: 8];
    case (pos)
      12: return 8'h08;
      13: return 8'h00;
      14: return 8'h45;
      15: return 8'h00;
      16: return tot_len[15:8];
      17: return tot_len[7:0];
      18: return 8'h00;
      19: return 8'h01;
      20: return 8'h40;
      21: return 8'h00;
      22: return 8'h62;
      23: return 8'h11;
      24: return frame_csum[15:8];
      25: return frame_csum[7:0];
      default: ;
    endcase
    if (pos < 30) return cfg_src_ip[8*(29-pos) +: 8];
    if (pos < 34) return cfg_dest_ip[8*(33-pos) +: 8];
    case (pos)
      34: return cfg_src_port[15:8];
      35: return cfg_src_port[7:0];
      36: return cfg_dest_port[15:8];
      37: return cfg_dest_port[7:0];
      38: return udp_len[15:8];
      39: return udp_len[7:0];
      40: return 8'h00;
      41: return 8'h00;
      default: ;
    endcase
    return seg_bytes[pos - FrameHdrBytes];
  endfunction

  // result of one push or pull, advancing the framer state
  function automatic udpf_pkg::out_item_t framer_predict(udpf_pkg::in_item_t beat);
    udpf_pkg::out_item_t r;
    r = '0;
    if (beat.operation == udpf_pkg::OP_PUSH) begin
      if (frame_ready) begin
        r.status = udpf_pkg::ST_REFUSED;
      end else begin
        if (seg_fill < SegBytes) begin
          seg_bytes[seg_fill] = beat.payload_byte;
          seg_fill++;
        end
        if (beat.end_of_message || seg_fill >= SegBytes) begin
          frame_ready = 1'b1;
          pull_pos = 0;
          frame_csum = ip_checksum(seg_fill);
        end
        r.status = udpf_pkg::ST_PUSHED;
      end
    end else if (frame_ready) begin
      r.status = udpf_pkg::ST_BYTE;
      r.frame_byte = frame_byte_at(pull_pos);
      if (pull_pos + 1 >= FrameHdrBytes + seg_fill) begin
        r.frame_last = 1'b1;
        frame_ready = 1'b0;
        seg_fill = 0;
        pull_pos = 0;
      end else begin
        pull_pos++;
      end
    end else begin
      r.status = udpf_pkg::ST_EMPTY;
    end
    return r;
  endfunction

  // input driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      seg_fill = 0;
      frame_ready = 1'b0;
      pull_pos = 0;
      frame_csum = '0;
    end else begin
      if (in_valid && !in_stall)
        results_due.insert(results_due.size(), framer_predict(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_error(input string why, input udpf_pkg::out_item_t want,
                            input udpf_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected status %0d byte %02h last %0b, got status %0d byte %02h last %0b",
               $time, why, want.status, want.frame_byte, want.frame_last,
               got.status, got.frame_byte, got.frame_last);
  endtask

  // result monitor and receiver stall pattern
  logic [15:0] stall_pattern = '0;
  int pat_cycle = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    udpf_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_taken++;
        case (out_data.status)
          udpf_pkg::ST_PUSHED: pushes_seen++;
          udpf_pkg::ST_REFUSED: refused_seen++;
          udpf_pkg::ST_BYTE: bytes_seen++;
          default: empty_seen++;
        endcase
        if (out_data.frame_last) frames_seen++;
        if (results_due.size() == 0) begin
          flag_error("result beat with nothing due", '0, out_data);
        end else begin
          want = results_due.pop_front();
          if (want.status !== out_data.status || want.frame_byte !== out_data.frame_byte ||
              want.frame_last !== out_data.frame_last)
            flag_error("result mismatch", want, out_data);
        end
      end
      pat_cycle++;
      if (pat_cycle % 64 == 0)
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
      // one long hold-off so the framer backs up into its input
      if (!long_hold_done && results_taken >= 300) begin
        hold_left = LongHold;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= stall_pattern[pat_cycle % 16];
      end
    end
  end

  // watchdog on cycles without any accepted beat
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat accepted for %0d cycles, %0d results still due",
               IdleLimit, results_due.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // register write: setup cycle, then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      udpf_pkg::REG_DEST_MAC: cfg_dest_mac = val[47:0];
      udpf_pkg::REG_SRC_MAC: cfg_src_mac = val[47:0];
      udpf_pkg::REG_SRC_IP: cfg_src_ip = val[31:0];
      udpf_pkg::REG_DEST_IP: cfg_dest_ip = val[31:0];
      udpf_pkg::REG_SRC_PORT: cfg_src_port = val[15:0];
      udpf_pkg::REG_DEST_PORT: cfg_dest_port = val[15:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic write_settings(input logic [63:0] dmac, input logic [63:0] smac,
                                input logic [63:0] sip, input logic [63:0] dip,
                                input logic [63:0] sport, input logic [63:0] dport);
    reg_write(udpf_pkg::REG_DEST_MAC, dmac);
    reg_write(udpf_pkg::REG_SRC_MAC, smac);
    reg_write(udpf_pkg::REG_SRC_IP, sip);
    reg_write(udpf_pkg::REG_DEST_IP, dip);
    reg_write(udpf_pkg::REG_SRC_PORT, sport);
    reg_write(udpf_pkg::REG_DEST_PORT, dport);
    // unmapped index must leave everything alone
    reg_write(RegUnused, {$urandom, $urandom});
  endtask

  task automatic add_beat(input logic op, input logic [7:0] b, input logic eom);
    udpf_pkg::in_item_t beat;
    beat.operation = op;
    beat.payload_byte = b;
    beat.end_of_message = eom;
    pending_beats.insert(pending_beats.size(), beat);
  endtask

  // wait until every beat is taken and every result has come back
  task automatic wait_drain();
    do @(negedge clk); while (pending_beats.size() != 0 || in_valid || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // one message: pushes, then the whole frame pulled, with some stray beats mixed in
  task automatic add_message(input int len, input bit close_by_count, inout int useful);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) add_beat(udpf_pkg::OP_PULL, 8'($urandom), 1'($urandom));
      add_beat(udpf_pkg::OP_PUSH, 8'($urandom), (i == len - 1) && !close_by_count);
    end
    if ($urandom_range(0, 3) == 0) add_beat(udpf_pkg::OP_PUSH, 8'($urandom), 1'($urandom));
    for (int i = 0; i < len + FrameHdrBytes; i++) begin
      if ($urandom_range(0, 29) == 0) add_beat(udpf_pkg::OP_PUSH, 8'($urandom), 1'($urandom));
      add_beat(udpf_pkg::OP_PULL, 8'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 4) == 0) add_beat(udpf_pkg::OP_PULL, 8'($urandom), 1'($urandom));
    useful += 2 * len + FrameHdrBytes;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 16);
    if (r < 19) return $urandom_range(17, 120);
    return $urandom_range(121, 400);
  endfunction

  // stimulus
  initial begin
    int useful;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: all-ones addresses, extremes of the byte, refusal, empty pulls
    write_settings('1, '1, '1, '1, '1, '1);
    add_beat(udpf_pkg::OP_PULL, 8'hFF, 1'b1);
    add_beat(udpf_pkg::OP_PUSH, 8'h00, 1'b0);
    add_beat(udpf_pkg::OP_PUSH, 8'hFF, 1'b1);
    add_beat(udpf_pkg::OP_PUSH, 8'hA5, 1'b1);
    for (int i = 0; i < 20; i++) add_beat(udpf_pkg::OP_PULL, 8'h00, 1'b0);
    wait_drain();
    // registers change while the frame is pending: checksum stays, fields follow
    reg_write(udpf_pkg::REG_DEST_MAC, 64'h0000_0123_4567_89AB);
    reg_write(udpf_pkg::REG_SRC_IP, 64'h0000_0000_0A00_0001);
    reg_write(udpf_pkg::REG_DEST_PORT, 64'h0000_0000_0000_0000);
    for (int i = 0; i < 24; i++) add_beat(udpf_pkg::OP_PULL, 8'hFF, 1'b1);
    add_beat(udpf_pkg::OP_PULL, 8'h5A, 1'b0);
    wait_drain();

    // random phases, one register setting each
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_settings('0, '0, '0, '0, '0, '0);
        1: write_settings('1, '1, '1, '1, '1, '1);
        4: write_settings({4{16'hAAAA}}, {4{16'h5555}}, {4{16'h5555}}, {4{16'hAAAA}},
                          {4{16'hAAAA}}, {4{16'h5555}});
        default: write_settings({$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      useful = 0;
      while (useful < 56) add_message(pick_len(), 1'b0, useful);
      wait_drain();
    end

    repeat (20) @(posedge clk);
    $display("run covered %0d result beats: %0d pushes, %0d refused, %0d frame bytes, %0d empty",
             results_taken, pushes_seen, refused_seen, bytes_seen, empty_seen);
    $display("%0d frames pulled out, %0d register writes over 7 settings, %0d mismatches",
             frames_seen, cfg_writes, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
